// ----- hw/rtl/mdpa_pkg.sv -----
// Shared types and constants for the minimum-distance point admission block.
// No dependencies; imported by every module of the block but mdpa_point_ram.
package mdpa_pkg;

    localparam int MIN_DIST_W = 22;
    localparam int MAX_PTS_W  = 8;
    localparam int SLOT_W     = 7;
    localparam int TOTAL_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 22;

    localparam logic [MIN_DIST_W-1:0] MIN_DIST_SQ_RST = 22'd100;
    localparam logic [MAX_PTS_W-1:0]  MAX_POINTS_RST  = 8'd25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DIST_SQ = 1'b0,
        CFG_MAX_POINTS  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

endpackage

// ----- hw/rtl/mdpa_point_ram.sv -----
// Point table: single-port-write, single-port-read RAM with registered read data.
// Holds packed {x, y} coordinates; depends on nothing.
module mdpa_point_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 20
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/mdpa_dist_unit.sv -----
// Pipelined squared-distance compare of the candidate against one stored point.
// Depends on mdpa_pkg.
module mdpa_dist_unit
    import mdpa_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  vld_in,
    input  logic [COORD_BITS-1:0] cand_x,
    input  logic [COORD_BITS-1:0] cand_y,
    input  logic [COORD_BITS-1:0] pt_x,
    input  logic [COORD_BITS-1:0] pt_y,
    input  logic [MIN_DIST_W-1:0] min_dist_sq,
    output logic                  busy,
    output logic                  close
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 1;
    localparam int CMP_W = (SUM_W > MIN_DIST_W) ? SUM_W : MIN_DIST_W;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [SQ_W-1:0]       sq_x_reg, sq_x_next;
    logic [SQ_W-1:0]       sq_y_reg, sq_y_next;
    logic                  vld_reg;
    logic [SUM_W-1:0]      sum;

    always_comb begin
        dx        = (cand_x >= pt_x) ? cand_x - pt_x : pt_x - cand_x;
        dy        = (cand_y >= pt_y) ? cand_y - pt_y : pt_y - cand_y;
        sq_x_next = SQ_W'(dx) * SQ_W'(dx);
        sq_y_next = SQ_W'(dy) * SQ_W'(dy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        sq_x_reg <= sq_x_next;
        sq_y_reg <= sq_y_next;
    end

    assign sum   = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg);
    assign busy  = vld_reg;
    assign close = vld_reg && (CMP_W'(sum) < CMP_W'(min_dist_sq));

endmodule

// ----- hw/rtl/min_distance_point_admission.sv -----
// Top level of the minimum-distance point admission block: control, counters, result register.
// Depends on mdpa_pkg, mdpa_point_ram and mdpa_dist_unit.
//
//   channel   ports                                           direction
//   request   s_valid s_ready s_cand_x s_cand_y s_last_cand   in
//   result    m_valid m_ready m_accepted m_slot m_point_total out
//   config    cfg_we cfg_index cfg_wdata                      in, write only
//
// An item that is compared has every stored point read and compared between acceptance and result,
// paced by the single read port of the point table (one stored point per cycle) and
// the distance pipeline; an item that is not compared goes straight to the result state.
// The next request is taken in the cycle after the result is registered.
// One request is in work at a time; the result register lets the next request in
// while a result waits. Reset is synchronous; the table needs no clearing pass.
module min_distance_point_admission
    import mdpa_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int COORD_BITS  = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_cand_x,
    input  logic [COORD_BITS-1:0] s_cand_y,
    input  logic                  s_last_cand,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_accepted,
    output logic [SLOT_W-1:0]     m_slot,
    output logic [TOTAL_W-1:0]    m_point_total,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W = (CNT_W > MAX_PTS_W) ? CNT_W : MAX_PTS_W;
    localparam int DW    = 2 * COORD_BITS;

    state_t                state_reg, state_next;
    logic [MIN_DIST_W-1:0] min_dist_reg, min_dist_next;
    logic [MAX_PTS_W-1:0]  max_pts_reg, max_pts_next;
    logic [CNT_W-1:0]      stored_reg, stored_next;
    logic [CNT_W-1:0]      frame_start_reg, frame_start_next;
    logic [CNT_W-1:0]      cand_idx_reg, cand_idx_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  considered_reg, considered_next;
    logic                  fail_reg, fail_next;
    logic [COORD_BITS-1:0] cx_reg, cx_next;
    logic [COORD_BITS-1:0] cy_reg, cy_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_accepted_reg, m_accepted_next;
    logic [SLOT_W-1:0]     m_slot_reg, m_slot_next;
    logic [TOTAL_W-1:0]    m_total_reg, m_total_next;

    logic [CNT_W-1:0]      fs;
    logic [LIM_W-1:0]      limit;
    logic [LIM_W-1:0]      free_space;
    logic                  considered;
    logic                  acc;
    logic                  rd_en;
    logic                  wr_en;
    logic [DW-1:0]         rd_data;
    logic                  dist_busy;
    logic                  close;

    mdpa_point_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (stored_reg[AW-1:0]),
        .wr_data ({cx_reg, cy_reg}),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    mdpa_dist_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .vld_in      (rd_pend_reg),
        .cand_x      (cx_reg),
        .cand_y      (cy_reg),
        .pt_x        (rd_data[DW-1:COORD_BITS]),
        .pt_y        (rd_data[COORD_BITS-1:0]),
        .min_dist_sq (min_dist_reg),
        .busy        (dist_busy),
        .close       (close)
    );

    always_comb begin
        fs         = (cand_idx_reg == '0) ? stored_reg : frame_start_reg;
        limit      = (LIM_W'(max_pts_reg) > LIM_W'(TABLE_DEPTH)) ?
                     LIM_W'(TABLE_DEPTH) : LIM_W'(max_pts_reg);
        free_space = (limit > LIM_W'(fs)) ? limit - LIM_W'(fs) : '0;
        considered = (LIM_W'(cand_idx_reg) < free_space) &&
                     (stored_reg < CNT_W'(TABLE_DEPTH));
        acc        = considered_reg && !fail_reg;
    end

    always_comb begin
        state_next       = state_reg;
        min_dist_next    = min_dist_reg;
        max_pts_next     = max_pts_reg;
        stored_next      = stored_reg;
        frame_start_next = frame_start_reg;
        cand_idx_next    = cand_idx_reg;
        issue_next       = issue_reg;
        rd_pend_next     = 1'b0;
        considered_next  = considered_reg;
        fail_next        = fail_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_accepted_next  = m_accepted_reg;
        m_slot_next      = m_slot_reg;
        m_total_next     = m_total_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;

        if (cfg_we) begin
            if (cfg_index == CFG_MIN_DIST_SQ) begin
                min_dist_next = cfg_wdata[MIN_DIST_W-1:0];
            end else if (cfg_index == CFG_MAX_POINTS) begin
                max_pts_next = cfg_wdata[MAX_PTS_W-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    frame_start_next = fs;
                    considered_next  = considered;
                    fail_next        = 1'b0;
                    issue_next       = '0;
                    cx_next          = s_cand_x;
                    cy_next          = s_cand_y;
                    if (s_last_cand) begin
                        cand_idx_next = '0;
                    end else if (cand_idx_reg < CNT_W'(TABLE_DEPTH)) begin
                        cand_idx_next = cand_idx_reg + CNT_W'(1);
                    end
                    state_next = (considered && stored_reg != '0) ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN: begin
                rd_en        = issue_reg < stored_reg;
                rd_pend_next = rd_en;
                fail_next    = fail_reg | close;
                if (rd_en) begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (!rd_en && !rd_pend_reg && !dist_busy) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    wr_en           = acc;
                    stored_next     = stored_reg + CNT_W'(acc);
                    m_valid_next    = 1'b1;
                    m_accepted_next = acc;
                    m_slot_next     = acc ? SLOT_W'(stored_reg) : '0;
                    m_total_next    = TOTAL_W'(stored_reg + CNT_W'(acc));
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            min_dist_reg    <= MIN_DIST_SQ_RST;
            max_pts_reg     <= MAX_POINTS_RST;
            stored_reg      <= '0;
            frame_start_reg <= '0;
            cand_idx_reg    <= '0;
            issue_reg       <= '0;
            rd_pend_reg     <= 1'b0;
            considered_reg  <= 1'b0;
            fail_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            min_dist_reg    <= min_dist_next;
            max_pts_reg     <= max_pts_next;
            stored_reg      <= stored_next;
            frame_start_reg <= frame_start_next;
            cand_idx_reg    <= cand_idx_next;
            issue_reg       <= issue_next;
            rd_pend_reg     <= rd_pend_next;
            considered_reg  <= considered_next;
            fail_reg        <= fail_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        m_accepted_reg <= m_accepted_next;
        m_slot_reg     <= m_slot_next;
        m_total_reg    <= m_total_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_accepted    = m_accepted_reg;
    assign m_slot        = m_slot_reg;
    assign m_point_total = m_total_reg;

endmodule

// ----- hw/rtl/mdpa_checker.sv -----
// Port-level checks on the result channel of the admission block.
// Depends on mdpa_pkg; bound to min_distance_point_admission below.
module mdpa_checker
    import mdpa_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_accepted,
    input logic [SLOT_W-1:0]  m_slot,
    input logic [TOTAL_W-1:0] m_point_total
);

    a_no_result_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

    a_slot_only_when_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_accepted) |-> (m_slot == '0))
        else $error("slot set on a rejected request");

    a_total_follows_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> (m_point_total[SLOT_W-1:0] == SLOT_W'(m_slot + 1'b1)))
        else $error("point total does not follow the written slot");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_accepted) && $stable(m_slot)
                                   && $stable(m_point_total)))
        else $error("stalled result changed");

endmodule

bind min_distance_point_admission mdpa_checker u_mdpa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_accepted    (m_accepted),
    .m_slot        (m_slot),
    .m_point_total (m_point_total)
);

// ----- sim/min_distance_point_admission_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for min_distance_point_admission: directed frames, then random phases.
// Depends on mdpa_pkg and the block's RTL; the expected verdicts come from an in-bench tracker.
module min_distance_point_admission_tb;
    import mdpa_pkg::*;

    localparam int TABLE_DEPTH = 128;
    localparam int COORD_W     = 10;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int HOLDOFF_LEN = 600;
    localparam int SETTLE_LEN  = TABLE_DEPTH + 12;

    typedef struct packed {
        logic               accepted;
        logic [SLOT_W-1:0]  slot;
        logic [TOTAL_W-1:0] total;
    } verdict_t;

    class admission_tracker;
        logic [COORD_W-1:0]    point_x [TABLE_DEPTH];
        logic [COORD_W-1:0]    point_y [TABLE_DEPTH];
        int unsigned           stored;
        int unsigned           frame_base;
        int unsigned           index_in_frame;
        logic [MIN_DIST_W-1:0] spacing_sq;
        logic [MAX_PTS_W-1:0]  capacity;
        verdict_t              due_verdicts[$];
        int unsigned           errors;

        function new();
            stored         = 0;
            frame_base     = 0;
            index_in_frame = 0;
            spacing_sq     = MIN_DIST_SQ_RST;
            capacity       = MAX_POINTS_RST;
            errors         = 0;
        endfunction

        function void write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_MIN_DIST_SQ: spacing_sq = value[MIN_DIST_W-1:0];
                CFG_MAX_POINTS:  capacity   = value[MAX_PTS_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending_count();
            return due_verdicts.size();
        endfunction

        function void admit_candidate(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                      logic closes_frame);
            verdict_t             v;
            int unsigned          span, room, dx, dy;
            longint unsigned      d2;
            logic                 admit;
            if (index_in_frame == 0) frame_base = stored;
            span  = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
            room  = (span > frame_base) ? span - frame_base : 0;
            admit = 1'b0;
            v     = '0;
            if (index_in_frame < room && stored < TABLE_DEPTH) begin
                admit = 1'b1;
                for (int i = 0; i < stored; i++) begin
                    dx = (x >= point_x[i]) ? x - point_x[i] : point_x[i] - x;
                    dy = (y >= point_y[i]) ? y - point_y[i] : point_y[i] - y;
                    d2 = longint'(dx) * dx + longint'(dy) * dy;
                    if (d2 < spacing_sq) admit = 1'b0;
                end
                if (admit) begin
                    v.slot          = SLOT_W'(stored);
                    point_x[stored] = x;
                    point_y[stored] = y;
                    stored++;
                end
            end
            if (closes_frame) index_in_frame = 0;
            else if (index_in_frame < TABLE_DEPTH) index_in_frame++;
            v.accepted = admit;
            v.total    = TOTAL_W'(stored);
            due_verdicts.push_back(v);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH %s", $time, what);
        endtask

        task check_verdict(logic accepted, logic [SLOT_W-1:0] slot, logic [TOTAL_W-1:0] total);
            verdict_t want;
            if (due_verdicts.size() == 0) begin
                report("result arrived with no request outstanding");
                return;
            end
            want = due_verdicts.pop_front();
            if (accepted !== want.accepted)
                report($sformatf("accepted got %b want %b", accepted, want.accepted));
            if (slot !== want.slot)
                report($sformatf("slot got %0d want %0d", slot, want.slot));
            if (total !== want.total)
                report($sformatf("point_total got %0d want %0d", total, want.total));
        endtask
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [COORD_W-1:0]    s_cand_x      = '0;
    logic [COORD_W-1:0]    s_cand_y      = '0;
    logic                  s_last_cand   = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_accepted;
    logic [SLOT_W-1:0]     m_slot;
    logic [TOTAL_W-1:0]    m_point_total;
    logic                  cfg_we        = 1'b0;
    cfg_index_t            cfg_index     = CFG_MIN_DIST_SQ;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    admission_tracker tracker = new();

    int unsigned rx_stall_pct  = 0;
    int unsigned holdoff_asked = 0;
    int unsigned holdoff_taken = 0;
    int unsigned holdoff_left  = 0;

    min_distance_point_admission #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .COORD_BITS (COORD_W)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cand_x     (s_cand_x),
        .s_cand_y     (s_cand_y),
        .s_last_cand  (s_last_cand),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accepted   (m_accepted),
        .m_slot       (m_slot),
        .m_point_total(m_point_total),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) tracker.check_verdict(m_accepted, m_slot, m_point_total);
            if (holdoff_left == 0 && holdoff_asked != holdoff_taken) begin
                holdoff_left = HOLDOFF_LEN;
                holdoff_taken++;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic offer_candidate(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                   input logic closes_frame, input int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cand_x    <= x;
        s_cand_y    <= y;
        s_last_cand <= closes_frame;
        do @(posedge aclk); while (!s_ready);
        tracker.admit_candidate(x, y, closes_frame);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_count() != 0);
    endtask

    task automatic load_settings(input logic [MIN_DIST_W-1:0] spacing,
                                 input logic [MAX_PTS_W-1:0] cap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_DIST_SQ;
        cfg_wdata <= CFG_DATA_W'(spacing);
        @(posedge aclk);
        cfg_index <= CFG_MAX_POINTS;
        cfg_wdata <= CFG_DATA_W'(cap);
        @(posedge aclk);
        cfg_we <= 1'b0;
        tracker.write_register(CFG_MIN_DIST_SQ, CFG_DATA_W'(spacing));
        tracker.write_register(CFG_MAX_POINTS, CFG_DATA_W'(cap));
    endtask

    // corners, near or exact copies of stored points, or anywhere in the frame
    task automatic pick_point(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
        int unsigned roll;
        int unsigned k;
        int          px, py;
        roll = $urandom_range(99);
        if (roll < 10) begin
            px = $urandom_range(1) ? COORD_MAX : 0;
            py = $urandom_range(1) ? COORD_MAX : 0;
        end else if (roll < 55 && tracker.stored > 0) begin
            k  = $urandom_range(tracker.stored - 1);
            px = int'(tracker.point_x[k]);
            py = int'(tracker.point_y[k]);
            if ($urandom_range(1)) begin
                px = px + int'($urandom_range(24)) - 12;
                py = py + int'($urandom_range(24)) - 12;
            end
        end else begin
            px = $urandom_range(COORD_MAX);
            py = $urandom_range(COORD_MAX);
        end
        if (px < 0) px = 0;
        if (px > COORD_MAX) px = COORD_MAX;
        if (py < 0) py = 0;
        if (py > COORD_MAX) py = COORD_MAX;
        x = COORD_W'(px);
        y = COORD_W'(py);
    endtask

    task automatic run_phase(input logic [MIN_DIST_W-1:0] spacing,
                             input logic [MAX_PTS_W-1:0] cap, input int unsigned items,
                             input int unsigned tx_pct, input int unsigned rx_pct,
                             input int unsigned long_first, input bit pause_frames,
                             input bit hold_receiver);
        int unsigned        sent;
        int unsigned        len;
        logic [COORD_W-1:0] x, y;
        sent = 0;
        load_settings(spacing, cap);
        rx_stall_pct <= rx_pct;
        if (hold_receiver) holdoff_asked <= holdoff_asked + 1;
        while (sent < items) begin
            if (sent == 0 && long_first != 0) len = long_first;
            else if ($urandom_range(39) == 0) len = $urandom_range(270, 129);
            else len = $urandom_range(24, 1);
            for (int n = 0; n < len && sent < items; n++) begin
                pick_point(x, y);
                offer_candidate(x, y, n == len - 1, tx_pct);
                sent++;
            end
            if (pause_frames && $urandom_range(3) == 0) drain_results();
        end
        drain_results();
    endtask

    task automatic run_directed();
        offer_candidate(0, 0, 1'b0, 0);
        offer_candidate(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), 1'b0, 0);
        offer_candidate(0, COORD_W'(COORD_MAX), 1'b0, 0);
        offer_candidate(COORD_W'(COORD_MAX), 0, 1'b0, 0);
        offer_candidate(10, 0, 1'b0, 0);
        offer_candidate(16, 8, 1'b0, 0);
        offer_candidate(5, 5, 1'b1, 0);
        drain_results();
        load_settings(0, 25);
        offer_candidate(0, 0, 1'b0, 0);
        offer_candidate(0, 0, 1'b1, 0);
        drain_results();
        load_settings(100, 7);
        offer_candidate(512, 512, 1'b0, 0);
        offer_candidate(300, 700, 1'b0, 0);
        offer_candidate(700, 300, 1'b1, 0);
        drain_results();
        load_settings(0, 10);
        offer_candidate(1, 1, 1'b0, 0);
        offer_candidate(1, 1, 1'b0, 0);
        offer_candidate(2, 2, 1'b0, 0);
        offer_candidate(3, 3, 1'b1, 0);
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_phase(100, 40, 200, 0, 0, 0, 1'b0, 1'b1);
        run_phase(22'd2097152, 128, 300, 64, 0, 0, 1'b0, 1'b0);
        run_phase(400, 71, 250, 0, 64, 0, 1'b1, 1'b0);
        run_phase(0, 81, 200, 14, 14, 260, 1'b0, 1'b0);
        run_phase(22'd2097151, 100, 100, 0, 0, 0, 1'b0, 1'b0);
        run_phase(MIN_DIST_W'($urandom_range(2097152)), 0, 60, 64, 0, 0, 1'b0, 1'b0);
        run_phase(1, 100, 200, 64, 0, 0, 1'b0, 1'b0);
        run_phase(MIN_DIST_W'($urandom_range(5000, 1000)), 128, 300, 0, 64, 0, 1'b0, 1'b0);
        run_phase(MIN_DIST_W'($urandom_range(300)), 128, 150, 14, 14, 0, 1'b0, 1'b0);
        repeat (SETTLE_LEN) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending_count() == 0)
            $display("min_distance_point_admission verification clean");
        else
            $display("min_distance_point_admission verification failed");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("min_distance_point_admission verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/mdpa_pkg.sv
hw/rtl/mdpa_point_ram.sv
hw/rtl/mdpa_dist_unit.sv
hw/rtl/min_distance_point_admission.sv
hw/rtl/mdpa_checker.sv
sim/min_distance_point_admission_tb.sv
